// File: hw/rtl/stream_dedup_first_occurrence_defines.svh
// assertion macros for the dedup block
`ifndef STREAM_DEDUP_FIRST_OCCURRENCE_DEFINES_SVH
`define STREAM_DEDUP_FIRST_OCCURRENCE_DEFINES_SVH

// same-cycle implication
`define SDFO_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SDFO_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/sdfo_pkg.sv
package sdfo_pkg;

    localparam int MAX_DISTINCT = 64;
    localparam int VALUE_W      = 32;
    localparam int COUNT_OUT_W  = 7;
    localparam int CNT_W        = $clog2(MAX_DISTINCT + 1);

    // word travelling down the cell chain
    typedef struct packed {
        logic                      valid;
        logic signed [VALUE_W-1:0] value;
        logic                      last;
        logic                      found;
        logic                      placed;
    } tok_t;

endpackage

// File: hw/rtl/sdfo_cell.sv
module sdfo_cell (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          advance,
    input  sdfo_pkg::tok_t tok_in,
    output sdfo_pkg::tok_t tok_out,
    output logic          occupied
);

    logic                               occ_reg;
    logic                               occ_next;
    logic signed [sdfo_pkg::VALUE_W-1:0] entry_reg;
    logic                               hit;
    logic                               place;
    sdfo_pkg::tok_t                     tok_next;
    logic                               valid_reg;
    logic signed [sdfo_pkg::VALUE_W-1:0] value_reg;
    logic                               last_reg;
    logic                               found_reg;
    logic                               placed_reg;

    assign hit   = occ_reg && (entry_reg == tok_in.value);
    assign place = tok_in.valid && !tok_in.found && !tok_in.placed && !occ_reg;

    always_comb
    begin
        tok_next        = tok_in;
        tok_next.found  = tok_in.found | (hit & !tok_in.placed);
        tok_next.placed = tok_in.placed | place;
    end

    // the last word of an array empties every cell it passes
    always_comb
    begin
        priority if (tok_in.valid && tok_in.last)
        begin
            occ_next = 1'b0;
        end
        else if (place)
        begin
            occ_next = 1'b1;
        end
        else
        begin
            occ_next = occ_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg   <= 1'b0;
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            occ_reg   <= occ_next;
            valid_reg <= tok_next.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            value_reg  <= tok_next.value;
            last_reg   <= tok_next.last;
            found_reg  <= tok_next.found;
            placed_reg <= tok_next.placed;
            if (place)
            begin
                entry_reg <= tok_in.value;
            end
        end
    end

    assign tok_out  = {valid_reg, value_reg, last_reg, found_reg, placed_reg};
    assign occupied = occ_reg;

endmodule

// File: hw/rtl/sdfo_tail.sv
module sdfo_tail (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                advance,
    input  sdfo_pkg::tok_t                      tok,
    output logic                                out_valid,
    output logic signed [sdfo_pkg::VALUE_W-1:0] value_out,
    output logic                                kept,
    output logic [sdfo_pkg::COUNT_OUT_W-1:0]    distinct_count,
    output logic                                end_out,
    output logic                                overflow
);

    logic [sdfo_pkg::CNT_W-1:0] cnt_reg;
    logic [sdfo_pkg::CNT_W-1:0] cnt_next;
    logic                       ovf_reg;
    logic                       ovf_next;
    logic                       valid_reg;
    logic                       take;

    assign take     = advance && tok.valid;
    assign cnt_next = tok.placed ? sdfo_pkg::CNT_W'(cnt_reg + 1'b1) : cnt_reg;
    // new value that found no free cell
    assign ovf_next = ovf_reg | (!tok.found & !tok.placed);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            ovf_reg   <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                valid_reg <= tok.valid;
            end
            if (take)
            begin
                cnt_reg <= tok.last ? '0 : cnt_next;
                ovf_reg <= tok.last ? 1'b0 : ovf_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            value_out      <= tok.value;
            kept           <= !tok.found;
            distinct_count <= sdfo_pkg::COUNT_OUT_W'(cnt_next);
            end_out        <= tok.last;
            overflow       <= ovf_next;
        end
    end

    assign out_valid = valid_reg;

endmodule

// File: hw/rtl/stream_dedup_first_occurrence.sv
// a result word is registered in each of the MAX_DISTINCT compare cells in turn and then
// in the output register of the tail
// throughput: one word per cycle unless a result is held under out_stall; each word walks the chain of MAX_DISTINCT
// compare cells one cell per cycle, the next word one cell behind it
// the whole chain holds while a result waits under out_stall
// reset clears cell occupancy, word valids, distinct count and overflow
`include "stream_dedup_first_occurrence_defines.svh"

module stream_dedup_first_occurrence (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [sdfo_pkg::VALUE_W-1:0] value,
    input  logic                                end_of_array,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [sdfo_pkg::VALUE_W-1:0] value_out,
    output logic                                kept,
    output logic [sdfo_pkg::COUNT_OUT_W-1:0]    distinct_count,
    output logic                                end_out,
    output logic                                overflow
);

    sdfo_pkg::tok_t                    tok_q [0:sdfo_pkg::MAX_DISTINCT];
    logic [sdfo_pkg::MAX_DISTINCT-1:0] occ;
    logic                              advance;

    assign advance = !(out_valid && out_stall);
    assign in_stall = !advance;

    // valid, value, last, found, placed
    assign tok_q[0] = {in_valid, value, end_of_array, 1'b0, 1'b0};

    for (genvar i = 0; i < sdfo_pkg::MAX_DISTINCT; i++)
    begin : g_cell
        sdfo_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .advance  (advance),
            .tok_in   (tok_q[i]),
            .tok_out  (tok_q[i+1]),
            .occupied (occ[i])
        );
    end

    sdfo_tail u_tail (
        .clk            (clk),
        .rst_n          (rst_n),
        .advance        (advance),
        .tok            (tok_q[sdfo_pkg::MAX_DISTINCT]),
        .out_valid      (out_valid),
        .value_out      (value_out),
        .kept           (kept),
        .distinct_count (distinct_count),
        .end_out        (end_out),
        .overflow       (overflow)
    );

    `SDFO_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(value_out) && $stable(end_out), "result word changed while stalled")
    `SDFO_ASSERT_NEXT(a_last_clears, clk, rst_n, advance && in_valid && end_of_array, !occ[0], "first cell not cleared by end word")
    `SDFO_ASSERT_NOW(a_found_or_placed, clk, rst_n, tok_q[sdfo_pkg::MAX_DISTINCT].valid, !(tok_q[sdfo_pkg::MAX_DISTINCT].found && tok_q[sdfo_pkg::MAX_DISTINCT].placed), "word both matched and stored")

endmodule
